[design/itra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itra_pkg
// Types, constants, control store and helper functions of the integer to
// radix text converter.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_CHARS   = VALUE_WIDTH;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int QUOT_W      = DIV_STEPS * DIV_BITS;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int DEPTH_W     = $clog2(MAX_CHARS + 1);
  localparam int PC_W        = 3;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(8'h61);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2D);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_PUSH,
    OP_SIGN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_DIV_MORE,
    C_MAG_NZ,
    C_MORE_DIGITS
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] PC_LOAD     = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV_INIT = PC_W'(1);
  localparam logic [PC_W-1:0] PC_DIV_STEP = PC_W'(2);
  localparam logic [PC_W-1:0] PC_PUSH     = PC_W'(3);
  localparam logic [PC_W-1:0] PC_SIGN     = PC_W'(4);
  localparam logic [PC_W-1:0] PC_EMIT     = PC_W'(5);
  localparam logic [PC_W-1:0] PC_RETURN   = PC_W'(6);

  function automatic ctrl_word_t control_store(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_LOAD:     w = '{op: OP_LOAD,     cond: C_NONE,        target: PC_LOAD};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NONE,        target: PC_LOAD};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,    target: PC_DIV_STEP};
      PC_PUSH:     w = '{op: OP_PUSH,     cond: C_MAG_NZ,      target: PC_DIV_INIT};
      PC_SIGN:     w = '{op: OP_SIGN,     cond: C_NONE,        target: PC_LOAD};
      PC_EMIT:     w = '{op: OP_EMIT,     cond: C_MORE_DIGITS, target: PC_EMIT};
      PC_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,      target: PC_LOAD};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,      target: PC_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    if (r < RADIX_MIN) begin
      e = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      e = RADIX_MAX;
    end else begin
      e = r;
    end
    return e;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d >= DIGIT_TEN) begin
      c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

[design/integer_to_radix_ascii_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core
// Converts a signed integer to ASCII text in a programmable base, most
// significant character first, with a flag on the final character.
// Each digit takes one setup step, 16 steps of a 4-bit-per-cycle restoring
// divider, and one push onto the digit stack. Then come a sign step, one
// emit step per character, and a return step.
// One transaction is converted at a time; the output register lets the next
// input be taken while the final character still waits.
// Synchronous active-low reset clears the sequencer, output valid, the digit
// stack depth and sets the radix to 10.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_core
  import itra_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [RADIX_W-1:0]        cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [63:0]        in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         out_char_code,
  output logic                      out_last_char
);

  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [QUOT_W-1:0]  quot_r, quot_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DIGIT_W-1:0] stack_r [MAX_CHARS];
  logic [DIGIT_W-1:0] stack_nxt [MAX_CHARS];
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  ctrl_word_t         ctrl;
  logic [RADIX_W-1:0] radix_eff;
  logic               out_free;
  logic               go;
  logic               cond_true;
  logic [VALUE_WIDTH-1:0] x;
  logic [VALUE_WIDTH-1:0] mag;
  logic [QUOT_W-1:0]  div_q;
  logic [DIGIT_W-1:0] div_rem;

  assign ctrl      = control_store(pc_r);
  assign radix_eff = clamp_radix(radix_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (ctrl.op != OP_LOAD);

  assign x = in_value[VALUE_WIDTH-1:0];

  always_comb begin
    if (x == SIGN_BIT) begin
      mag = SIGN_BIT - VALUE_WIDTH'(1);
    end else if (x[VALUE_WIDTH-1]) begin
      mag = ~x + VALUE_WIDTH'(1);
    end else begin
      mag = x;
    end
  end

  always_comb begin
    logic [DIGIT_W:0]   sh;
    logic [DIGIT_W-1:0] r;
    logic [QUOT_W-1:0]  q;
    r = rem_r;
    q = quot_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      sh = {r, q[QUOT_W-1]};
      q  = {q[QUOT_W-2:0], 1'b0};
      if (sh >= {1'b0, radix_eff}) begin
        sh   = sh - {1'b0, radix_eff};
        q[0] = 1'b1;
      end
      r = sh[DIGIT_W-1:0];
    end
    div_q   = q;
    div_rem = r;
  end

  always_comb begin
    case (ctrl.op)
      OP_LOAD: go = in_valid;
      OP_SIGN: go = !neg_r || out_free;
      OP_EMIT: go = out_free;
      default: go = 1'b1;
    endcase

    case (ctrl.cond)
      C_NONE:        cond_true = 1'b0;
      C_ALWAYS:      cond_true = 1'b1;
      C_DIV_MORE:    cond_true = (cnt_r != CNT_W'(DIV_STEPS - 1));
      C_MAG_NZ:      cond_true = (quot_r != '0);
      C_MORE_DIGITS: cond_true = (depth_r > DEPTH_W'(1));
      default:       cond_true = 1'b0;
    endcase

    if (!go) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_comb begin
    radix_nxt     = cfg_wr_en ? cfg_wr_data : radix_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    depth_nxt     = depth_r;
    stack_nxt     = stack_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (ctrl.op)
      OP_LOAD: begin
        if (in_valid) begin
          quot_nxt  = QUOT_W'(mag);
          neg_nxt   = x[VALUE_WIDTH-1];
          depth_nxt = '0;
        end
      end
      OP_DIV_INIT: begin
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        quot_nxt = div_q;
        rem_nxt  = div_rem;
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
      OP_PUSH: begin
        stack_nxt[0] = rem_r;
        for (int i = 1; i < MAX_CHARS; i++) begin
          stack_nxt[i] = stack_r[i-1];
        end
        depth_nxt = depth_r + DEPTH_W'(1);
      end
      OP_SIGN: begin
        if (neg_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(stack_r[0]);
          out_last_nxt  = (depth_r == DEPTH_W'(1));
          for (int i = 0; i < MAX_CHARS - 1; i++) begin
            stack_nxt[i] = stack_r[i+1];
          end
          depth_nxt = depth_r - DEPTH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_LOAD;
      radix_r     <= RADIX_RESET;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      radix_r     <= radix_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    stack_r    <= stack_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule
